### sv/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, a, c)
`define ASSERT_NEXT(label, clk, rstn, a, c)
`endif
`endif

### sv/cpio_pkg.sv
`timescale 1ns / 1ps
package cpio_pkg;
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_NAME    = 3'd1,
        PH_NAMEPAD = 3'd2,
        PH_DATA    = 3'd3,
        PH_DATAPAD = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERROR   = 3'd6
    } phase_t;

    localparam int unsigned HEADER_LEN = 110;
    localparam int unsigned FIFO_DEPTH = 4;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  region;
        logic        region_last;
        logic [31:0] file_size;
        logic        is_trailer;
    } cls_t;

    function automatic logic [7:0] magic_char(input logic [2:0] i);
        case (i)
            3'd0: magic_char = 8'h30;
            3'd1: magic_char = 8'h37;
            3'd2: magic_char = 8'h30;
            3'd3: magic_char = 8'h37;
            3'd4: magic_char = 8'h30;
            3'd5: magic_char = 8'h31;
            default: magic_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] trailer_char(input logic [3:0] i);
        case (i)
            4'd0: trailer_char = 8'h54;
            4'd1: trailer_char = 8'h52;
            4'd2: trailer_char = 8'h41;
            4'd3: trailer_char = 8'h49;
            4'd4: trailer_char = 8'h4C;
            4'd5: trailer_char = 8'h45;
            4'd6: trailer_char = 8'h52;
            4'd7, 4'd8, 4'd9: trailer_char = 8'h21;
            default: trailer_char = 8'h00;
        endcase
    endfunction

    // Returns {valid, nibble}.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        if (b inside {[8'h30:8'h39]}) begin
            hex_digit = {1'b1, b[3:0]};
        end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            hex_digit = {1'b1, b[3:0] + 4'd9};
        end else begin
            hex_digit = 5'd0;
        end
    endfunction
endpackage

### sv/cpio_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cpio_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    output logic              in_ready,
    output cpio_pkg::cls_t    cls,
    output logic              cls_valid,
    input  logic              cls_ready,
    output logic              entry_bump
);
    cpio_pkg::phase_t phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] name_len_reg, name_len_next;
    logic [31:0] data_len_reg, data_len_next;
    logic [31:0] hex_reg, hex_next;
    logic        trl_reg, trl_next;

    logic        fire, err, last, hex_field;
    logic [4:0]  hd;
    logic [31:0] cnt_inc, rlen, nm_len_eff;
    logic        trl_eff;
    logic        namepad_nz, data_nz, datapad_nz;

    assign in_ready  = cls_ready;
    assign cls_valid = in_valid;
    assign fire      = in_valid && cls_ready;
    assign hd        = cpio_pkg::hex_digit(in_byte);
    assign cnt_inc   = count_reg + 32'd1;
    assign hex_field = (count_reg >= 32'd54 && count_reg <= 32'd61) ||
                       (count_reg >= 32'd94 && count_reg <= 32'd101);

    always_comb begin
        err = 1'b0;
        if (phase_reg == cpio_pkg::PH_ERROR) begin
            err = 1'b1;
        end else if (phase_reg == cpio_pkg::PH_HEADER) begin
            if (count_reg < 32'd6) begin
                err = (in_byte != cpio_pkg::magic_char(count_reg[2:0]));
            end else if (hex_field) begin
                err = !hd[4];
            end
        end
    end

    always_comb begin
        case (phase_reg)
            cpio_pkg::PH_HEADER:  rlen = 32'(cpio_pkg::HEADER_LEN);
            cpio_pkg::PH_NAME:    rlen = name_len_reg;
            cpio_pkg::PH_NAMEPAD: rlen = {30'd0, 2'd2 - name_len_reg[1:0]};
            cpio_pkg::PH_DATA:    rlen = data_len_reg;
            cpio_pkg::PH_DATAPAD: rlen = {30'd0, 2'd0 - data_len_reg[1:0]};
            default:              rlen = 32'd0;
        endcase
    end
    assign last = (phase_reg != cpio_pkg::PH_DONE) && !err && (cnt_inc >= rlen);

    always_comb begin
        hex_next      = hex_reg;
        name_len_next = name_len_reg;
        data_len_next = data_len_reg;
        trl_next      = trl_reg;
        if (phase_reg == cpio_pkg::PH_HEADER && hex_field && hd[4]) begin
            hex_next = {hex_reg[27:0], hd[3:0]};
            if (count_reg == 32'd61) begin
                data_len_next = hex_next;
                hex_next      = 32'd0;
            end
            if (count_reg == 32'd101) begin
                name_len_next = hex_next;
                hex_next      = 32'd0;
            end
        end
        if (phase_reg == cpio_pkg::PH_NAME &&
            (count_reg > 32'd10 || in_byte != cpio_pkg::trailer_char(count_reg[3:0]))) begin
            trl_next = 1'b0;
        end
        if (err) begin
            hex_next = 32'd0;
        end
    end

    // Name length and trailer flag as they stand once the header ends.
    assign nm_len_eff = name_len_next;
    assign trl_eff    = (phase_reg == cpio_pkg::PH_HEADER) ? (nm_len_eff == 32'd11)
                                                          : trl_next;
    assign namepad_nz = (2'd2 - nm_len_eff[1:0]) != 2'd0;
    assign data_nz    = data_len_next != 32'd0;
    assign datapad_nz = data_len_next[1:0] != 2'd0;

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        entry_bump = 1'b0;
        if (err) begin
            phase_next = cpio_pkg::PH_ERROR;
        end else if (phase_reg != cpio_pkg::PH_DONE) begin
            count_next = cnt_inc;
            if (last) begin
                count_next = 32'd0;
                if (phase_reg == cpio_pkg::PH_HEADER && nm_len_eff != 32'd0) begin
                    phase_next = cpio_pkg::PH_NAME;
                end else if (phase_reg <= cpio_pkg::PH_NAME && namepad_nz) begin
                    phase_next = cpio_pkg::PH_NAMEPAD;
                end else if (phase_reg <= cpio_pkg::PH_NAMEPAD && data_nz) begin
                    phase_next = cpio_pkg::PH_DATA;
                end else if (phase_reg <= cpio_pkg::PH_DATA && datapad_nz) begin
                    phase_next = cpio_pkg::PH_DATAPAD;
                end else if (trl_eff) begin
                    phase_next = cpio_pkg::PH_DONE;
                end else begin
                    phase_next = cpio_pkg::PH_HEADER;
                    entry_bump = fire;
                end
            end
        end
    end

    always_comb begin
        cls.out_byte    = in_byte;
        cls.region      = err ? cpio_pkg::PH_ERROR : phase_reg;
        cls.region_last = last;
        cls.file_size   = err ? 32'd0 : data_len_next;
        cls.is_trailer  = !err && (phase_reg == cpio_pkg::PH_DONE ||
                          (phase_reg != cpio_pkg::PH_HEADER && trl_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= cpio_pkg::PH_HEADER;
            count_reg    <= 32'd0;
            name_len_reg <= 32'd0;
            data_len_reg <= 32'd0;
            hex_reg      <= 32'd0;
            trl_reg      <= 1'b1;
        end else if (fire) begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            name_len_reg <= name_len_next;
            data_len_reg <= data_len_next;
            hex_reg      <= hex_next;
            trl_reg      <= (last && phase_next == cpio_pkg::PH_HEADER) ? 1'b1 : trl_eff;
        end
    end

    `ASSERT_NEXT(a_err_sticky, aclk, aresetn, phase_reg == cpio_pkg::PH_ERROR,
        phase_reg == cpio_pkg::PH_ERROR)
    `ASSERT_IMPLIES(a_err_no_last, aclk, aresetn, err, !last)
    `ASSERT_IMPLIES(a_bump_last, aclk, aresetn, entry_bump, last && fire)
endmodule

### sv/cpio_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cpio_back #(
    parameter int unsigned IDX_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cpio_pkg::cls_t        cls,
    input  logic                  cls_valid,
    output logic                  cls_ready,
    input  logic                  entry_bump,
    output cpio_pkg::cls_t        out_cls,
    output logic [IDX_BITS-1:0]   out_idx,
    output logic                  out_valid,
    input  logic                  out_ready
);
    localparam int unsigned AW = $clog2(cpio_pkg::FIFO_DEPTH);
    typedef struct packed {
        cpio_pkg::cls_t        c;
        logic [IDX_BITS-1:0]   idx;
    } ent_t;

    ent_t          mem_reg [cpio_pkg::FIFO_DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg, cnt_next;
    logic [IDX_BITS-1:0] ecnt_reg;
    logic push, pop;

    assign cls_ready = cnt_reg != (AW+1)'(cpio_pkg::FIFO_DEPTH);
    assign push      = cls_valid && cls_ready;
    assign out_valid = cnt_reg != '0;
    assign pop       = out_valid && out_ready;
    assign out_cls   = mem_reg[rp_reg].c;
    assign out_idx   = mem_reg[rp_reg].idx;
    assign cnt_next  = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= '{c: cls, idx: ecnt_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            cnt_reg  <= '0;
            ecnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + AW'(1);
            if (pop)  rp_reg <= rp_reg + AW'(1);
            cnt_reg <= cnt_next;
            if (entry_bump && ecnt_reg != '1) ecnt_reg <= ecnt_reg + IDX_BITS'(1);
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, aclk, aresetn, 1'b1,
        cnt_reg <= (AW+1)'(cpio_pkg::FIFO_DEPTH))
    `ASSERT_NEXT(a_idx_sat, aclk, aresetn, ecnt_reg == '1, ecnt_reg == '1)
endmodule

### sv/cpio_newc_stream_deframer.sv
`timescale 1ns / 1ps
// Streaming deframer for newc cpio archives. One archive byte enters per item
// on the s_ channel and one labeled item leaves on the m_ channel for each, at
// one item per clock unless a side stalls; each is registered in the queue.
// The front checks the header magic, decodes the hex sizes and tracks regions
// combinationally; a four-entry queue feeds the output, so an input stall
// never stops it and an output stall stops the input only once it is full.
// A bad magic or bad hex digit locks the block in the error region until reset.
module cpio_newc_stream_deframer #(
    parameter int unsigned ENTRY_INDEX_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_byte, [39:8] file_size, [40] is_trailer, [56:41] entry_index
    output logic [63:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [2:0] region
    output logic        m_axis_tlast    // region_last
);
    cpio_pkg::cls_t cls, out_cls;
    logic cls_valid, cls_ready, bump;
    logic [ENTRY_INDEX_BITS-1:0] idx;
    logic [15:0] idx16;

    cpio_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_byte(s_axis_tdata), .in_ready(s_axis_tready),
        .cls(cls), .cls_valid(cls_valid), .cls_ready(cls_ready), .entry_bump(bump)
    );

    cpio_back #(.IDX_BITS(ENTRY_INDEX_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cls(cls), .cls_valid(cls_valid), .cls_ready(cls_ready), .entry_bump(bump),
        .out_cls(out_cls), .out_idx(idx), .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready)
    );

    // The reported index is the low 16 bits of the counter.
    assign idx16 = 16'(32'(idx));
    assign m_axis_tdata = {7'd0, idx16, out_cls.is_trailer, out_cls.file_size,
                           out_cls.out_byte};
    assign m_axis_tuser = out_cls.region;
    assign m_axis_tlast = out_cls.region_last;
endmodule
